// ===== rtl/core/cobs_crc_pkg.sv =====
`default_nettype none

package cobs_crc_pkg;

  // Frame size limits
  localparam int unsigned MAX_ENCODED_BYTES = 256;
  localparam int unsigned ENC_W             = $clog2(MAX_ENCODED_BYTES + 1);
  localparam int unsigned MIN_FRAME_BYTES   = 8;
  localparam int unsigned CRC_BYTES         = 4;

  // CRC-32, reflected form
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  // Result kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // End-of-frame status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_FRAMING   = 3'd2;
  localparam logic [2:0] ST_OTHER     = 3'd3;
  localparam logic [2:0] ST_CRC_ERR   = 3'd4;
  localparam logic [2:0] ST_OVERFLOW  = 3'd5;

  // One result word
  typedef struct packed {
    logic       result_kind;
    logic [7:0] data_byte;
    logic [2:0] frame_status;
    logic [7:0] message_length;
    logic       last_flag;
  } result_t;

  // Fold one byte into the running CRC, one bit per step.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cobs_crc_ifs.sv =====
`default_nettype none

// Encoded byte channel.
interface cobs_crc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// Station address write channel.
interface cobs_crc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] station_addr;
  modport source (output valid, output station_addr, input ready);
  modport sink (input valid, input station_addr, output ready);
endinterface

// Result channel.
interface cobs_crc_result_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] data_byte;
  logic [2:0] frame_status;
  logic [7:0] message_length;
  logic       last_flag;
  modport source (output valid, output result_kind, output data_byte, output frame_status,
                  output message_length, output last_flag, input ready);
  modport sink (input valid, input result_kind, input data_byte, input frame_status,
                input message_length, input last_flag, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cobs_crc_in_stage.sv =====
`default_nettype none

module cobs_crc_in_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_data,
  output logic            in_ready,
  input  wire logic       advance,
  output logic            stage_valid,
  output logic [7:0]      stage_byte
);

  // The register frees up when empty or when its word moves on this cycle.
  assign in_ready = !stage_valid || advance;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  // Byte register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_byte <= in_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cobs_crc_decoder.sv =====
`default_nettype none

module cobs_crc_decoder (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 advance,
  input  wire logic [7:0]           b,
  input  wire logic [7:0]           station_addr,
  output logic                      emit,
  output cobs_crc_pkg::result_t     result
);

  // Frame state
  logic [cobs_crc_pkg::ENC_W-1:0] encoded_count, encoded_count_next;
  logic [7:0]                     block_remaining, block_remaining_next;
  logic                           block_was_full, block_was_full_next;
  logic                           framing_bad, framing_bad_next;
  logic [7:0]                     decoded_count, decoded_count_next;
  logic [7:0]                     holdback [4];
  logic [7:0]                     holdback_next [4];
  logic [31:0]                    running_crc, running_crc_next;
  logic                           address_mismatch, address_mismatch_next;

  // Next state and result for the byte in the input register
  always_comb begin
    logic       push_en;
    logic [7:0] push_val;
    logic       clear;
    logic       mismatch;
    logic [2:0] st;
    logic [7:0] len;

    encoded_count_next    = encoded_count;
    block_remaining_next  = block_remaining;
    block_was_full_next   = block_was_full;
    framing_bad_next      = framing_bad;
    decoded_count_next    = decoded_count;
    holdback_next         = holdback;
    running_crc_next      = running_crc;
    address_mismatch_next = address_mismatch;
    emit                  = 1'b0;
    result                = '0;
    push_en               = 1'b0;
    push_val              = b;
    clear                 = 1'b0;
    mismatch              = address_mismatch;
    st                    = cobs_crc_pkg::ST_OK;
    len                   = 8'd0;

    if (b == 8'd0) begin
      // Delimiter: close the frame with a status word.
      if (encoded_count < cobs_crc_pkg::ENC_W'(cobs_crc_pkg::MIN_FRAME_BYTES)) begin
        st = cobs_crc_pkg::ST_SHORT;
      end else if (block_remaining != 8'd0 || framing_bad ||
                   decoded_count < 8'(cobs_crc_pkg::CRC_BYTES)) begin
        st = cobs_crc_pkg::ST_FRAMING;
      end else if (address_mismatch) begin
        st = cobs_crc_pkg::ST_OTHER;
      end else if (~running_crc != {holdback[3], holdback[2], holdback[1], holdback[0]}) begin
        st = cobs_crc_pkg::ST_CRC_ERR;
      end else begin
        st  = cobs_crc_pkg::ST_OK;
        len = decoded_count - 8'(cobs_crc_pkg::CRC_BYTES);
      end
      emit                  = 1'b1;
      result.result_kind    = cobs_crc_pkg::KIND_STATUS;
      result.frame_status   = st;
      result.message_length = len;
      result.last_flag      = 1'b1;
      clear                 = 1'b1;
    end else if (encoded_count >= cobs_crc_pkg::ENC_W'(cobs_crc_pkg::MAX_ENCODED_BYTES)) begin
      // Frame too long: drop the byte and start over.
      emit                = 1'b1;
      result.result_kind  = cobs_crc_pkg::KIND_STATUS;
      result.frame_status = cobs_crc_pkg::ST_OVERFLOW;
      result.last_flag    = 1'b1;
      clear               = 1'b1;
    end else begin
      encoded_count_next = encoded_count + 1'b1;
      if (block_remaining == 8'd0) begin
        // Code byte: a finished short block implies a zero.
        block_remaining_next = b - 8'd1;
        block_was_full_next  = (b == 8'hFF);
        push_en              = !block_was_full;
        push_val             = 8'd0;
      end else begin
        block_remaining_next = block_remaining - 8'd1;
        push_en              = 1'b1;
        push_val             = b;
      end
    end

    // Decoded byte into the holdback; the oldest one leaves toward the CRC.
    if (push_en) begin
      if (decoded_count == 8'hFF) begin
        framing_bad_next = 1'b1;
      end else begin
        if (decoded_count == 8'd0) begin
          mismatch = (push_val != station_addr);
        end
        address_mismatch_next = mismatch;
        holdback_next[0]      = holdback[1];
        holdback_next[1]      = holdback[2];
        holdback_next[2]      = holdback[3];
        holdback_next[3]      = push_val;
        decoded_count_next    = decoded_count + 8'd1;
        if (decoded_count >= 8'(cobs_crc_pkg::CRC_BYTES)) begin
          running_crc_next = cobs_crc_pkg::crc_byte(running_crc, holdback[0]);
          if (!mismatch) begin
            emit               = 1'b1;
            result.result_kind = cobs_crc_pkg::KIND_DATA;
            result.data_byte   = holdback[0];
          end
        end
      end
    end

    // Every status word returns the frame to its initial state.
    if (clear) begin
      encoded_count_next    = '0;
      block_remaining_next  = 8'd0;
      block_was_full_next   = 1'b1;
      framing_bad_next      = 1'b0;
      decoded_count_next    = 8'd0;
      holdback_next         = '{default: 8'd0};
      running_crc_next      = cobs_crc_pkg::CRC_INIT;
      address_mismatch_next = 1'b0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      encoded_count    <= '0;
      block_remaining  <= 8'd0;
      block_was_full   <= 1'b1;
      framing_bad      <= 1'b0;
      decoded_count    <= 8'd0;
      holdback         <= '{default: 8'd0};
      running_crc      <= cobs_crc_pkg::CRC_INIT;
      address_mismatch <= 1'b0;
    end else if (advance) begin
      encoded_count    <= encoded_count_next;
      block_remaining  <= block_remaining_next;
      block_was_full   <= block_was_full_next;
      framing_bad      <= framing_bad_next;
      decoded_count    <= decoded_count_next;
      holdback         <= holdback_next;
      running_crc      <= running_crc_next;
      address_mismatch <= address_mismatch_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cobs_crc_out_stage.sv =====
`default_nettype none

module cobs_crc_out_stage (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load,
  input  wire cobs_crc_pkg::result_t load_word,
  output logic                       free,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output cobs_crc_pkg::result_t      out_word
);

  // The register can take a new word when empty or being drained now.
  assign free = !out_valid || out_ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (free && load) begin
      out_word <= load_word;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cobs_crc32_frame_receiver.sv =====
`default_nettype none

// COBS frame receiver with CRC-32 check. One encoded byte per word comes in
// on in_ch, a zero byte closing the frame. Decoded message bytes go out on
// out_ch as data words once they have left a four-byte holdback (the trailing
// little-endian CRC-32, reflected 0xEDB88320, init and final xor all ones),
// and only if the frame's first decoded byte equals the station address. Every
// delimiter gives one status word with last_flag set: short, framing error,
// other address, CRC error, or ok with the message length; a frame longer
// than 256 encoded bytes gives an overflow status and restarts. Data already
// sent stays sent: the status tells whether it was good. Each byte passes an
// input register and the decode, CRC and status logic into a result register.
// The block takes one byte per clock cycle while out_ch is ready; a result
// word left waiting on out_ch holds the byte in the input register and so
// stalls in_ch. The station address is written on cfg, which is always ready,
// and should only change between frames.
module cobs_crc32_frame_receiver (
  input  wire logic         clk,
  input  wire logic         rst,
  cobs_crc_byte_if.sink     in_ch,
  cobs_crc_cfg_if.sink      cfg,
  cobs_crc_result_if.source out_ch
);

  logic                  stage_valid;
  logic [7:0]            stage_byte;
  logic                  advance;
  logic                  out_free;
  logic                  emit;
  cobs_crc_pkg::result_t core_word;
  cobs_crc_pkg::result_t out_word;
  logic [7:0]            station_addr;

  // Address register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      station_addr <= 8'd0;
    end else if (cfg.valid) begin
      station_addr <= cfg.station_addr;
    end
  end

  // The held byte is processed whenever the result register can take a word.
  assign advance = stage_valid && out_free;

  cobs_crc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_data    (in_ch.in_byte),
    .in_ready   (in_ch.ready),
    .advance    (advance),
    .stage_valid(stage_valid),
    .stage_byte (stage_byte)
  );

  cobs_crc_decoder u_dec (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .b           (stage_byte),
    .station_addr(station_addr),
    .emit        (emit),
    .result      (core_word)
  );

  cobs_crc_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && emit),
    .load_word(core_word),
    .free     (out_free),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_word (out_word)
  );

  // Result fields
  assign out_ch.result_kind    = out_word.result_kind;
  assign out_ch.data_byte      = out_word.data_byte;
  assign out_ch.frame_status   = out_word.frame_status;
  assign out_ch.message_length = out_word.message_length;
  assign out_ch.last_flag      = out_word.last_flag;

endmodule

`default_nettype wire

// ===== test/tb_cobs_crc32_frame_receiver.sv =====
module tb_cobs_crc32_frame_receiver;

  localparam int LONG_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 6;
  localparam int STALL_LIMIT = 3000;
  localparam int RANDOM_BYTES = 240;

  typedef logic [7:0] octet_q_t [$];

  typedef enum {
    FR_GOOD,
    FR_FOREIGN,
    FR_BAD_CRC,
    FR_CORRUPT,
    FR_TRUNCATED,
    FR_NOISE
  } frame_kind_t;

  // Tracks the receiver's decode state and the words it owes on the result channel.
  class frame_scoreboard;
    logic [7:0] device_addr;
    int enc_count;
    logic [7:0] blk_left;
    logic blk_full;
    logic frame_bad;
    int dec_count;
    logic [7:0] tail [4];
    logic [31:0] crc_acc;
    logic addr_miss;
    cobs_crc_pkg::result_t pending_results [$];
    int errors;
    int bytes_taken;
    int data_words;
    int status_seen [6];

    function void clear_frame();
      enc_count = 0;
      blk_left = 8'h00;
      blk_full = 1'b1;
      frame_bad = 1'b0;
      dec_count = 0;
      foreach (tail[i]) tail[i] = 8'h00;
      crc_acc = cobs_crc_pkg::CRC_INIT;
      addr_miss = 1'b0;
    endfunction

    function void reset_all();
      device_addr = 8'h00;
      clear_frame();
      errors = 0;
      bytes_taken = 0;
      data_words = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // Reflected CRC-32, one bit per pass.
    static function logic [31:0] crc_fold(logic [31:0] c, logic [7:0] d);
      logic [31:0] acc;
      acc = c ^ {24'd0, d};
      repeat (8) acc = acc[0] ? ((acc >> 1) ^ cobs_crc_pkg::CRC_POLY) : (acc >> 1);
      return acc;
    endfunction

    function void expect_word(logic kind, logic [7:0] d, logic [2:0] st, logic [7:0] len);
      cobs_crc_pkg::result_t r;
      r.result_kind = kind;
      r.data_byte = d;
      r.frame_status = st;
      r.message_length = len;
      r.last_flag = (kind == cobs_crc_pkg::KIND_STATUS);
      pending_results.push_back(r);
      if (kind == cobs_crc_pkg::KIND_STATUS) status_seen[st]++;
      else data_words++;
    endfunction

    // A decoded byte enters the four-byte CRC holdback; the byte it pushes out is message.
    function void push_decoded(logic [7:0] d);
      logic [7:0] leaving;
      if (dec_count == 255) begin
        frame_bad = 1'b1;
        return;
      end
      if (dec_count == 0) addr_miss = (d != device_addr);
      leaving = tail[0];
      tail[0] = tail[1];
      tail[1] = tail[2];
      tail[2] = tail[3];
      tail[3] = d;
      dec_count++;
      if (dec_count > cobs_crc_pkg::CRC_BYTES) begin
        crc_acc = crc_fold(crc_acc, leaving);
        if (!addr_miss)
          expect_word(cobs_crc_pkg::KIND_DATA, leaving, cobs_crc_pkg::ST_OK, 8'h00);
      end
    endfunction

    // The delimiter closes the frame with one status word, in order of precedence.
    function void close_frame();
      logic [2:0] st;
      logic [7:0] len;
      logic [31:0] rx;
      len = 8'h00;
      rx = {tail[3], tail[2], tail[1], tail[0]};
      if (enc_count < cobs_crc_pkg::MIN_FRAME_BYTES) st = cobs_crc_pkg::ST_SHORT;
      else if (blk_left != 0 || frame_bad || dec_count < cobs_crc_pkg::CRC_BYTES)
        st = cobs_crc_pkg::ST_FRAMING;
      else if (addr_miss) st = cobs_crc_pkg::ST_OTHER;
      else if ((crc_acc ^ cobs_crc_pkg::CRC_INIT) != rx) st = cobs_crc_pkg::ST_CRC_ERR;
      else begin
        st = cobs_crc_pkg::ST_OK;
        len = 8'(dec_count - cobs_crc_pkg::CRC_BYTES);
      end
      clear_frame();
      expect_word(cobs_crc_pkg::KIND_STATUS, 8'h00, st, len);
    endfunction

    function void take_encoded_byte(logic [7:0] b);
      logic zero_first;
      bytes_taken++;
      if (b == 8'h00) close_frame();
      else if (enc_count >= cobs_crc_pkg::MAX_ENCODED_BYTES) begin
        clear_frame();
        expect_word(cobs_crc_pkg::KIND_STATUS, 8'h00, cobs_crc_pkg::ST_OVERFLOW, 8'h00);
      end else begin
        enc_count++;
        if (blk_left == 8'h00) begin
          // A code byte; the block before it implies a zero unless it was full.
          zero_first = !blk_full;
          blk_left = b - 8'd1;
          blk_full = (b == 8'hFF);
          if (zero_first) push_decoded(8'h00);
        end else begin
          blk_left--;
          push_decoded(b);
        end
      end
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void compare_result(cobs_crc_pkg::result_t got);
      cobs_crc_pkg::result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual kind %0d data %0h status %0d",
                 $time, got.result_kind, got.data_byte, got.frame_status);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      check_field("result_kind", want.result_kind, got.result_kind);
      check_field("data_byte", want.data_byte, got.data_byte);
      check_field("frame_status", want.frame_status, got.frame_status);
      check_field("message_length", want.message_length, got.message_length);
      check_field("last_flag", want.last_flag, got.last_flag);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic idle_on;
  logic long_hold_req;
  frame_scoreboard sb;

  cobs_crc_byte_if in_ch ();
  cobs_crc_cfg_if cfg_ch ();
  cobs_crc_result_if out_ch ();

  cobs_crc32_frame_receiver u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .cfg    (cfg_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Note accepted bytes first, then check the result word taken at the same edge.
  always @(posedge clk) begin
    if (rst === 1'b0) begin
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) sb.take_encoded_byte(in_ch.in_byte);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        sb.compare_result({out_ch.result_kind, out_ch.data_byte, out_ch.frame_status,
                           out_ch.message_length, out_ch.last_flag});
    end
  end

  // Result side back-pressure: random stall bursts, plus one long hold on request.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 25)) @(posedge clk);
      end
    end
  end

  // Ends the run when no word moves on any channel for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
          (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: timeout, nothing moved for %0d cycles", $time, STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // Message with its little-endian CRC-32 appended; crc_flip spoils the check on purpose.
  function automatic octet_q_t make_message(logic [7:0] first, int payload_len, int zero_pct,
                                            logic [31:0] crc_flip);
    octet_q_t msg;
    logic [31:0] c;
    msg.push_back(first);
    for (int i = 0; i < payload_len; i++)
      msg.push_back(($urandom_range(0, 99) < zero_pct) ? 8'h00 : 8'($urandom_range(1, 255)));
    c = cobs_crc_pkg::CRC_INIT;
    foreach (msg[i]) c = frame_scoreboard::crc_fold(c, msg[i]);
    c = c ^ cobs_crc_pkg::CRC_INIT ^ crc_flip;
    for (int i = 0; i < 4; i++) msg.push_back(c[8*i +: 8]);
    return msg;
  endfunction

  // Plain COBS encoding, without the trailing delimiter.
  function automatic octet_q_t stuff_bytes(octet_q_t plain);
    octet_q_t enc;
    int code_at;
    logic [7:0] run;
    code_at = 0;
    enc.push_back(8'h00);
    run = 8'd1;
    foreach (plain[i]) begin
      if (plain[i] == 8'h00) begin
        enc[code_at] = run;
        code_at = enc.size();
        enc.push_back(8'h00);
        run = 8'd1;
      end else begin
        enc.push_back(plain[i]);
        run++;
        if (run == 8'hFF) begin
          enc[code_at] = run;
          code_at = enc.size();
          enc.push_back(8'h00);
          run = 8'd1;
        end
      end
    end
    enc[code_at] = run;
    return enc;
  endfunction

  task automatic send_encoded(logic [7:0] b);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  task automatic send_frame(octet_q_t enc);
    foreach (enc[i]) send_encoded(enc[i]);
    send_encoded(8'h00);
  endtask

  // Sender pauses until every owed word has come and the pipeline has emptied.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_address(logic [7:0] a);
    cfg_ch.valid <= 1'b1;
    cfg_ch.station_addr <= a;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    sb.device_addr = a;
  endtask

  // Mostly well-formed frames with random content; the rest broken or plain noise.
  task automatic send_random_frame();
    frame_kind_t k;
    octet_q_t enc;
    int r;
    int len;
    int cut;
    logic [7:0] first;
    logic [31:0] flip;
    r = $urandom_range(0, 99);
    k = (r < 60) ? FR_GOOD : (r < 70) ? FR_FOREIGN : (r < 78) ? FR_BAD_CRC :
        (r < 86) ? FR_CORRUPT : (r < 94) ? FR_TRUNCATED : FR_NOISE;
    if (k == FR_NOISE) begin
      repeat ($urandom_range(1, 20))
        send_encoded(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
    end else begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(200, 250) : $urandom_range(0, 24);
      first = (k == FR_FOREIGN) ? (sb.device_addr ^ 8'($urandom_range(1, 255))) : sb.device_addr;
      flip = (k == FR_BAD_CRC) ? (32'h1 << $urandom_range(0, 31)) : 32'h0;
      enc = stuff_bytes(make_message(first, len, $urandom_range(0, 50), flip));
      if (k == FR_CORRUPT) enc[$urandom_range(0, enc.size() - 1)] = 8'($urandom_range(1, 255));
      if (k == FR_TRUNCATED) begin
        cut = $urandom_range(1, enc.size() - 1);
        repeat (cut) void'(enc.pop_back());
      end
      send_frame(enc);
    end
  endtask

  initial begin
    logic [7:0] phase_addr [4];
    octet_q_t enc;
    int goal;
    sb = new;
    sb.reset_all();
    idle_on = 1'b1;
    long_hold_req = 1'b0;
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.in_byte <= 8'h00;
    cfg_ch.valid <= 1'b0;
    cfg_ch.station_addr <= 8'h00;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The address register comes out of reset as zero.
    send_frame(stuff_bytes(make_message(8'h00, 6, 0, 32'h0)));
    wait_idle();
    write_address(8'h5A);

    // Directed frames: too short to count, good, zeros in the payload, foreign address,
    // bad CRC, an unfinished block, a bare delimiter, a full 254-byte block, and overflow.
    send_frame(stuff_bytes(make_message(8'h5A, 0, 0, 32'h0)));
    send_frame(stuff_bytes(make_message(8'h5A, 3, 0, 32'h0)));
    send_frame(stuff_bytes(make_message(8'h5A, 12, 50, 32'h0)));
    send_frame(stuff_bytes(make_message(8'hA5, 6, 0, 32'h0)));
    send_frame(stuff_bytes(make_message(8'h5A, 6, 0, 32'h8000_0001)));
    enc = {8'h20, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h40, 8'h80, 8'hFF};
    send_frame(enc);
    send_encoded(8'h00);
    send_frame(stuff_bytes(make_message(8'h5A, 249, 0, 32'h0)));
    enc = {};
    repeat (cobs_crc_pkg::MAX_ENCODED_BYTES + 4) enc.push_back(8'($urandom_range(1, 255)));
    send_frame(enc);
    wait_idle();

    // Random phases, each with its own address; the last one runs without gaps.
    phase_addr[0] = 8'h00;
    phase_addr[1] = 8'hFF;
    phase_addr[2] = 8'($urandom_range(1, 254));
    phase_addr[3] = 8'($urandom_range(0, 255));
    goal = sb.bytes_taken;
    for (int p = 0; p < 4; p++) begin
      write_address(phase_addr[p]);
      if (p == 1) begin
        // Hold the result side off while a good frame keeps coming.
        long_hold_req = 1'b1;
        send_frame(stuff_bytes(make_message(phase_addr[p], 40, 10, 32'h0)));
      end
      if (p == 3) idle_on = 1'b0;
      goal = goal + RANDOM_BYTES / 4;
      while (sb.bytes_taken < goal) send_random_frame();
      wait_idle();
    end

    $display("Run took %0d encoded bytes across several address settings,", sb.bytes_taken);
    $display("with gaps, stalls and a long output hold.");
    $display("Closed frames: ok %0d, short %0d, framing %0d, other %0d, crc %0d, overflow %0d;",
             sb.status_seen[cobs_crc_pkg::ST_OK], sb.status_seen[cobs_crc_pkg::ST_SHORT],
             sb.status_seen[cobs_crc_pkg::ST_FRAMING], sb.status_seen[cobs_crc_pkg::ST_OTHER],
             sb.status_seen[cobs_crc_pkg::ST_CRC_ERR],
             sb.status_seen[cobs_crc_pkg::ST_OVERFLOW]);
    $display("data words %0d.", sb.data_words);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/cobs_crc_pkg.sv
rtl/core/cobs_crc_ifs.sv
rtl/core/cobs_crc_in_stage.sv
rtl/core/cobs_crc_decoder.sv
rtl/core/cobs_crc_out_stage.sv
rtl/core/cobs_crc32_frame_receiver.sv
test/tb_cobs_crc32_frame_receiver.sv
